// File: rtl/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared types and codes of the multi-pattern byte matcher: item kinds,
// table entry layouts and the memory command bundle.
// ----------------------------------------------------------------------------
package mpbm_pkg;

    localparam int STATE_W = 10;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 8;
    localparam int KIND_W  = 3;

    localparam logic [KIND_W-1:0] KIND_SCAN   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GOTO   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LENGTH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SUFFIX = 3'd4;

    // One goto table entry.
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] target;
    } goto_t;

    // Per-state entry: fail link, word length and dictionary-suffix link.
    typedef struct packed {
        logic [STATE_W-1:0] fail;
        logic [LEN_W-1:0]   len;
        logic               sfx_valid;
        logic [STATE_W-1:0] sfx;
    } info_t;

    // One input item as unpacked from the stream.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  byte_value;
        logic [STATE_W-1:0] entry_state;
        logic [STATE_W-1:0] target_state;
        logic               entry_valid;
        logic [LEN_W-1:0]   word_len;
        logic               last_in_chunk;
    } item_t;

    // Memory commands from the sequencer to the two tables.
    typedef struct packed {
        logic [STATE_W-1:0] goto_state;
        logic [BYTE_W-1:0]  goto_byte;
        logic               goto_we;
        goto_t              goto_wdata;
        logic [STATE_W-1:0] info_state;
        logic               info_we;
        info_t              info_wdata;
    } mem_cmd_t;

endpackage

// File: rtl/mpbm_ram.sv
// ----------------------------------------------------------------------------
// mpbm_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module mpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mpbm_seq.sv
// ----------------------------------------------------------------------------
// mpbm_seq
// Matcher sequencer: walks goto and fail links through the table memories,
// resolves the reported word length, merges per-state table writes and
// holds the result register.
// ----------------------------------------------------------------------------
module mpbm_seq #(
    parameter int NUM_STATES   = 1024,
    parameter int MAX_WORD_LEN = 255
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mpbm_pkg::item_t               in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mpbm_pkg::LEN_W-1:0]    out_len,
    output logic [mpbm_pkg::STATE_W-1:0]  out_state,
    output mpbm_pkg::mem_cmd_t            cmd,
    input  mpbm_pkg::goto_t               goto_rd,
    input  mpbm_pkg::info_t               info_rd
);

    localparam int STEP_W = $clog2(NUM_STATES + 1);
    localparam logic [16:0] NUM_STATES_W = 17'(NUM_STATES);
    localparam logic [16:0] MAX_LEN_W    = 17'(MAX_WORD_LEN);
    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(NUM_STATES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_TARGET,
        ST_SUFFIX,
        ST_EMIT,
        ST_MODIFY
    } seq_state_t;

    function automatic logic in_range(input logic [mpbm_pkg::STATE_W-1:0] s);
        in_range = {7'd0, s} < NUM_STATES_W;
    endfunction

    seq_state_t                   state_reg, state_next;
    logic [mpbm_pkg::STATE_W-1:0] cur_state_reg, cur_state_next;
    logic                         anchor_reg, anchor_next;
    logic                         m_valid_reg, m_valid_next;
    logic [mpbm_pkg::LEN_W-1:0]   m_len_reg, m_len_next;
    logic [mpbm_pkg::STATE_W-1:0] m_state_reg, m_state_next;
    logic [mpbm_pkg::STATE_W-1:0] walk_reg, walk_next;
    logic [mpbm_pkg::BYTE_W-1:0]  byte_reg, byte_next;
    logic                         last_reg, last_next;
    logic [STEP_W-1:0]            steps_reg, steps_next;
    logic [mpbm_pkg::STATE_W-1:0] res_state_reg, res_state_next;
    logic [mpbm_pkg::LEN_W-1:0]   res_len_reg, res_len_next;
    logic [mpbm_pkg::KIND_W-1:0]  wr_kind_reg, wr_kind_next;
    logic [mpbm_pkg::STATE_W-1:0] wr_entry_reg, wr_entry_next;
    logic [mpbm_pkg::STATE_W-1:0] wr_target_reg, wr_target_next;
    logic                         wr_valid_reg, wr_valid_next;
    logic [mpbm_pkg::LEN_W-1:0]   wr_len_reg, wr_len_next;
    logic                         walk_ok;

    always_comb begin
        state_next     = state_reg;
        cur_state_next = cur_state_reg;
        anchor_next    = cfg_we ? cfg_wdata : anchor_reg;
        m_valid_next   = (m_valid_reg && out_ready) ? 1'b0 : m_valid_reg;
        m_len_next     = m_len_reg;
        m_state_next   = m_state_reg;
        walk_next      = walk_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        steps_next     = steps_reg;
        res_state_next = res_state_reg;
        res_len_next   = res_len_reg;
        wr_kind_next   = wr_kind_reg;
        wr_entry_next  = wr_entry_reg;
        wr_target_next = wr_target_reg;
        wr_valid_next  = wr_valid_reg;
        wr_len_next    = wr_len_reg;
        in_ready       = 1'b0;
        walk_ok        = in_range(walk_reg);

        cmd            = '0;
        cmd.goto_state = cur_state_reg;
        cmd.goto_byte  = in_item.byte_value;
        cmd.info_state = cur_state_reg;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (in_item.kind) inside
                        mpbm_pkg::KIND_SCAN: begin
                            walk_next  = cur_state_reg;
                            byte_next  = in_item.byte_value;
                            last_next  = in_item.last_in_chunk;
                            steps_next = '0;
                            state_next = ST_LOOKUP;
                        end
                        mpbm_pkg::KIND_GOTO: begin
                            cmd.goto_state        = in_item.entry_state;
                            cmd.goto_we           = in_range(in_item.entry_state);
                            cmd.goto_wdata.valid  = in_item.entry_valid;
                            cmd.goto_wdata.target = in_item.entry_valid ?
                                                    in_item.target_state : '0;
                        end
                        mpbm_pkg::KIND_FAIL, mpbm_pkg::KIND_LENGTH,
                        mpbm_pkg::KIND_SUFFIX: begin
                            // Read the entry now, merge the new field next cycle.
                            cmd.info_state = in_item.entry_state;
                            wr_kind_next   = in_item.kind;
                            wr_entry_next  = in_item.entry_state;
                            wr_target_next = in_item.target_state;
                            wr_valid_next  = in_item.entry_valid;
                            wr_len_next    = ({9'd0, in_item.word_len} > MAX_LEN_W) ?
                                             MAX_LEN_W[mpbm_pkg::LEN_W-1:0] :
                                             in_item.word_len;
                            if (in_range(in_item.entry_state)) begin
                                state_next = ST_MODIFY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (walk_ok && goto_rd.valid) begin
                    res_state_next = goto_rd.target;
                    cmd.info_state = goto_rd.target;
                    state_next     = ST_TARGET;
                end else if (steps_reg >= STEP_LIMIT) begin
                    // Walk too long: fall back to the root, report nothing.
                    res_state_next = '0;
                    res_len_next   = '0;
                    state_next     = ST_EMIT;
                end else begin
                    walk_next      = walk_ok ? info_rd.fail : '0;
                    steps_next     = steps_reg + 1'b1;
                    cmd.goto_state = walk_next;
                    cmd.goto_byte  = byte_reg;
                    cmd.info_state = walk_next;
                end
            end
            ST_TARGET: begin
                cmd.info_state = info_rd.sfx;
                if (!in_range(res_state_reg)) begin
                    res_len_next = '0;
                    state_next   = ST_EMIT;
                end else if (info_rd.len != '0) begin
                    res_len_next = info_rd.len;
                    state_next   = ST_EMIT;
                end else if (info_rd.sfx_valid && in_range(info_rd.sfx)) begin
                    state_next = ST_SUFFIX;
                end else begin
                    res_len_next = '0;
                    state_next   = ST_EMIT;
                end
            end
            ST_SUFFIX: begin
                res_len_next = info_rd.len;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the result register is free.
                if (!m_valid_reg || out_ready) begin
                    m_valid_next   = 1'b1;
                    m_len_next     = (last_reg && anchor_reg) ? '0 : res_len_reg;
                    m_state_next   = res_state_reg;
                    cur_state_next = res_state_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_MODIFY: begin
                cmd.info_state = wr_entry_reg;
                cmd.info_we    = 1'b1;
                cmd.info_wdata = info_rd;
                case (wr_kind_reg) inside
                    mpbm_pkg::KIND_FAIL:   cmd.info_wdata.fail = wr_target_reg;
                    mpbm_pkg::KIND_LENGTH: cmd.info_wdata.len  = wr_len_reg;
                    default: begin
                        cmd.info_wdata.sfx_valid = wr_valid_reg;
                        cmd.info_wdata.sfx       = wr_valid_reg ? wr_target_reg : '0;
                    end
                endcase
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        m_len_reg     <= m_len_next;
        m_state_reg   <= m_state_next;
        walk_reg      <= walk_next;
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        steps_reg     <= steps_next;
        res_state_reg <= res_state_next;
        res_len_reg   <= res_len_next;
        wr_kind_reg   <= wr_kind_next;
        wr_entry_reg  <= wr_entry_next;
        wr_target_reg <= wr_target_next;
        wr_valid_reg  <= wr_valid_next;
        wr_len_reg    <= wr_len_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_state_reg <= '0;
            anchor_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_state_reg <= cur_state_next;
            anchor_reg    <= anchor_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_len   = m_len_reg;
    assign out_state = m_state_reg;

endmodule

// File: rtl/multi_pattern_byte_matcher_unit.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_unit
// Byte-stream multi-pattern matcher on a host-loaded automaton held in a
// goto memory and a per-state memory (fail, length, suffix).
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser kind, tdata fields, tlast
//  m_*       out        m_tvalid / m_tready  tdata hit_len, state_after
//  cfg_*     in         cfg_we               cfg_wdata = anchor_end
//
//  Scan: goto lookup and fail steps (one read of both table memories each),
//  then the target's and maybe the suffix entry; gives up after NUM_STATES steps.
//  A goto write lands on acceptance; fail, length or suffix: read, then merge.
//  Reset clears the automaton state to 0 and anchor_end; tables are not cleared.
//  A waiting result holds in m_tdata; the next item is taken meanwhile and only
//  a second finished scan waits for m_tready.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher_unit #(
    parameter int NUM_STATES   = 1024,
    parameter int MAX_WORD_LEN = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] byte_value, [17:8] entry_state, [27:18] target_state,
    // [28] entry_valid, [36:29] word_len, [39:37] zero
    input  logic [39:0] s_tdata,
    // [2:0] kind
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] hit_len, [17:8] state_after, [23:18] zero
    output logic [23:0] m_tdata
);

    localparam int TBL_DEPTH  = (NUM_STATES < 1024) ? NUM_STATES : 1024;
    localparam int SAW        = $clog2(TBL_DEPTH);
    localparam int GOTO_DEPTH = TBL_DEPTH * 256;

    mpbm_pkg::item_t                item;
    mpbm_pkg::mem_cmd_t             cmd;
    mpbm_pkg::goto_t                goto_rd;
    mpbm_pkg::info_t                info_rd;
    logic [mpbm_pkg::LEN_W-1:0]     out_len;
    logic [mpbm_pkg::STATE_W-1:0]   out_state;
    logic [SAW+7:0]                 goto_addr;
    logic [SAW-1:0]                 info_addr;

    always_comb begin
        item.kind          = s_tuser;
        item.byte_value    = s_tdata[7:0];
        item.entry_state   = s_tdata[17:8];
        item.target_state  = s_tdata[27:18];
        item.entry_valid   = s_tdata[28];
        item.word_len      = s_tdata[36:29];
        item.last_in_chunk = s_tlast;
    end

    assign goto_addr = {cmd.goto_state[SAW-1:0], cmd.goto_byte};
    assign info_addr = cmd.info_state[SAW-1:0];

    mpbm_seq #(
        .NUM_STATES   (NUM_STATES),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_len   (out_len),
        .out_state (out_state),
        .cmd       (cmd),
        .goto_rd   (goto_rd),
        .info_rd   (info_rd)
    );

    mpbm_ram #(
        .WIDTH ($bits(mpbm_pkg::goto_t)),
        .DEPTH (GOTO_DEPTH)
    ) u_goto_ram (
        .aclk  (aclk),
        .we    (cmd.goto_we),
        .waddr (goto_addr),
        .wdata (cmd.goto_wdata),
        .raddr (goto_addr),
        .rdata (goto_rd)
    );

    mpbm_ram #(
        .WIDTH ($bits(mpbm_pkg::info_t)),
        .DEPTH (TBL_DEPTH)
    ) u_info_ram (
        .aclk  (aclk),
        .we    (cmd.info_we),
        .waddr (info_addr),
        .wdata (cmd.info_wdata),
        .raddr (info_addr),
        .rdata (info_rd)
    );

    assign m_tdata = {6'd0, out_state, out_len};

`ifndef NO_ASSERTIONS
    // A scan item keeps the sequencer busy for at least the next cycle.
    a_scan_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == mpbm_pkg::KIND_SCAN) |=> !s_tready)
        else $error("input taken right after a scan item");

    // A goto write lands only in the cycle its item is accepted.
    a_goto_we: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.goto_we |-> (s_tvalid && s_tready && s_tuser == mpbm_pkg::KIND_GOTO))
        else $error("goto write without a goto item");

    // A per-state write comes in the cycle after its read.
    a_info_we: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.info_we |-> $past(s_tvalid && s_tready &&
                              (s_tuser == mpbm_pkg::KIND_FAIL ||
                               s_tuser == mpbm_pkg::KIND_LENGTH ||
                               s_tuser == mpbm_pkg::KIND_SUFFIX)))
        else $error("per-state write without a preceding write item");
`endif

endmodule
